### src/note_sine_tone_generator_defines.svh
// Assertion helpers for the tone generator.
`ifndef NOTE_SINE_TONE_GENERATOR_DEFINES_SVH
`define NOTE_SINE_TONE_GENERATOR_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted.
`define NSTG_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define NSTG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/nstg_pkg.sv
`default_nettype none

package nstg_pkg;

    // Datapath sizes
    localparam int PHASE_BITS       = 32;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SAMPLE_BITS      = 16;

    localparam int ADDR_BITS = $clog2(SINE_TABLE_DEPTH);
    localparam int QBITS     = ADDR_BITS - 2;
    localparam int QSIZE     = SINE_TABLE_DEPTH / 4;
    localparam int MAG_BITS  = SAMPLE_BITS - 1;
    localparam int LEN_BITS  = 20;
    localparam int OUT_BITS  = 16;

    localparam logic [LEN_BITS-1:0] WHOLE_RESET = LEN_BITS'(44100);

    // Command codes (s_tuser)
    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_NOTE = 2'd1;
    localparam logic [1:0] CMD_REST = 2'd2;

    // Mode codes, also sent as period kind
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_TONE = 2'd1;
    localparam logic [1:0] MODE_GAP  = 2'd2;

    typedef struct packed {
        logic [1:0] cmd;
        logic [3:0] note_index;
        logic [3:0] octave;
        logic [2:0] value_code;
    } item_t;

    // Base frequencies in hundredths of a Hz, C through B
    localparam int unsigned NOTE_CENTIHZ [12] = '{
        1635, 1732, 1835, 1945, 2060, 2183, 2312, 2450, 2596, 2750, 2914, 3087
    };

    // Step scale: 44100 Hz times 100, rounding half up
    localparam longint unsigned STEP_DIV  = 64'd4410000;
    localparam longint unsigned STEP_HALF = 64'd2205000;

    typedef logic [PHASE_BITS-1:0] step_rom_t [16];
    typedef logic [MAG_BITS-1:0] quarter_rom_t [QSIZE];

    function automatic logic [PHASE_BITS-1:0] step_of(int unsigned c);
        longint unsigned v;
        v = ((longint'(c) << PHASE_BITS) + STEP_HALF) / STEP_DIV;
        return v[PHASE_BITS-1:0];
    endfunction

    // Indexes above B play B
    function automatic step_rom_t build_step_rom();
        step_rom_t r;
        for (int i = 0; i < 16; i++) begin
            r[i] = step_of(NOTE_CENTIHZ[(i > 11) ? 11 : i]);
        end
        return r;
    endfunction

    // Quarter-wave magnitude for offset k, order-9 Taylor polynomial in Q30
    function automatic logic [MAG_BITS-1:0] quarter_sine(int unsigned k);
        longint unsigned one;
        longint unsigned amp;
        longint unsigned z;
        longint unsigned z2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned mag;
        one = 64'd1 << 30;
        amp = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
        z   = longint'(k) << (32 - ADDR_BITS);
        z2  = (z * z) >> 30;
        t   = 64'd172273;
        t   = 64'd5026996 - ((z2 * t) >> 30);
        t   = 64'd85569306 - ((z2 * t) >> 30);
        t   = 64'd693598668 - ((z2 * t) >> 30);
        t   = 64'd1686629713 - ((z2 * t) >> 30);
        s   = (z * t) >> 30;
        mag = (s * amp + (one >> 1)) >> 30;
        if (mag > amp) begin
            mag = amp;
        end
        return mag[MAG_BITS-1:0];
    endfunction

    function automatic quarter_rom_t build_quarter_rom();
        quarter_rom_t r;
        for (int i = 0; i < QSIZE; i++) begin
            r[i] = quarter_sine(i);
        end
        return r;
    endfunction

    localparam step_rom_t BASE_STEP_ROM = build_step_rom();
    localparam quarter_rom_t QUARTER_ROM = build_quarter_rom();
    // Entry at the quarter point, reached from odd quadrants only
    localparam logic [MAG_BITS-1:0] QUARTER_PEAK = quarter_sine(QSIZE);

endpackage

`default_nettype wire

### src/note_sine_tone_generator.sv
// Channel   Dir  Transfer when         Contents
// s_axis    in   s_tvalid & s_tready   tick / note / rest command
// m_axis    out  m_tvalid & m_tready   one sine sample per tick
// cfg       in   cfg_valid & cfg_ready whole-note length in ticks
//
// One item per cycle sustained while m_axis is not stalled. A tick is held in the
// input register after its transfer and is loaded into the result register
// once that register is free or draining; m_tvalid rises when the result
// register is loaded. Commands give no result.
// The sequencer between the two registers is combinational.
// Reset (aresetn low, synchronous) clears mode, counters and phase, and sets
// the whole-note length to 44100. A stalled m_axis holds the result and
// backs up into the input register; s_tready drops only when both are full.
`default_nettype none
`include "note_sine_tone_generator_defines.svh"

module note_sine_tone_generator (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [3:0] note_index, [7:4] octave, [10:8] value_code, [15:11] zero
    input  wire logic [15:0] s_tdata,
    // [1:0] cmd
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [15:0] sample
    output logic [15:0]      m_tdata,
    // [1:0] period_kind
    output logic [1:0]       m_tuser,
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [19:0] cfg_data
);
    import nstg_pkg::*;

    logic                in_valid_reg;
    item_t               in_item_reg;
    logic [LEN_BITS-1:0] whole_len_reg;
    logic                item_take;
    logic signed [OUT_BITS-1:0] out_sample;

    assign cfg_ready = 1'b1;

    // Whole-note length register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            whole_len_reg <= WHOLE_RESET;
        end else if (cfg_valid) begin
            whole_len_reg <= cfg_data;
        end
    end

    // Input register
    assign s_tready = !in_valid_reg || item_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.cmd        <= s_tuser;
            in_item_reg.note_index <= s_tdata[3:0];
            in_item_reg.octave     <= s_tdata[7:4];
            in_item_reg.value_code <= s_tdata[10:8];
        end
    end

    nstg_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (in_valid_reg),
        .item       (in_item_reg),
        .whole_len  (whole_len_reg),
        .item_take  (item_take),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_sample (out_sample),
        .out_kind   (m_tuser),
        .out_last   (m_tlast)
    );

    assign m_tdata = out_sample;

    // Period end is only ever flagged in a silent tick
    `NSTG_ASSERT_IMPL(a_last_in_gap, aclk, aresetn, m_tvalid && m_tlast, m_tuser == MODE_GAP, "last outside gap")

    // Only a sounding tick carries a nonzero sample
    `NSTG_ASSERT_IMPL(a_silent_zero, aclk, aresetn, m_tvalid && (m_tuser != MODE_TONE), m_tdata == '0, "sample while silent")

    // Input side stalls only when the result side is full and stalled
    `NSTG_ASSERT_IMPL(a_stall_cause, aclk, aresetn, !s_tready, m_tvalid && !m_tready, "input stall without output stall")

    // A pending item with a free result register is taken
    `NSTG_ASSERT_NEXT(a_no_hold, aclk, aresetn, in_valid_reg && !m_tvalid && !s_tvalid, !in_valid_reg, "item held with free output")

endmodule

`default_nettype wire

### src/nstg_sine_lut.sv
`default_nettype none

module nstg_sine_lut (
    input  wire logic [nstg_pkg::PHASE_BITS-1:0] phase,
    output logic signed [nstg_pkg::OUT_BITS-1:0] sample
);
    import nstg_pkg::*;

    logic [ADDR_BITS-1:0]       addr;
    logic [1:0]                 quad;
    logic [QBITS:0]             offs;
    logic [MAG_BITS-1:0]        mag;
    logic signed [SAMPLE_BITS-1:0] full;
    logic signed [31:0]         wide;

    // Quadrant folding on the top phase bits
    assign addr = phase[PHASE_BITS-1 -: ADDR_BITS];
    assign quad = addr[ADDR_BITS-1 -: 2];
    assign offs = quad[0] ? ((QBITS+1)'(QSIZE) - {1'b0, addr[QBITS-1:0]})
                          : {1'b0, addr[QBITS-1:0]};
    assign mag  = offs[QBITS] ? QUARTER_PEAK : QUARTER_ROM[offs[QBITS-1:0]];

    // Sign in the lower half-wave, then fit to the 16-bit port
    assign full   = quad[1] ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
    assign wide   = 32'(full);
    assign sample = wide[OUT_BITS-1:0];

endmodule

`default_nettype wire

### src/nstg_core.sv
`default_nettype none

module nstg_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            item_valid,
    input  wire nstg_pkg::item_t                 item,
    input  wire logic [nstg_pkg::LEN_BITS-1:0]   whole_len,
    output logic                                 item_take,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic signed [nstg_pkg::OUT_BITS-1:0] out_sample,
    output logic [1:0]                           out_kind,
    output logic                                 out_last
);
    import nstg_pkg::*;

    logic [PHASE_BITS-1:0] phase_acc_reg, phase_acc_next;
    logic [PHASE_BITS-1:0] phase_step_reg, phase_step_next;
    logic [LEN_BITS-1:0]   tone_left_reg, tone_left_next;
    logic [LEN_BITS-1:0]   gap_left_reg, gap_left_next;
    logic [1:0]            mode_reg, mode_next;

    logic                  out_valid_reg;
    logic signed [OUT_BITS-1:0] sample_reg, sample_next;
    logic [1:0]            kind_reg, kind_next;
    logic                  last_reg, last_next;
    logic                  emit;

    logic [LEN_BITS-1:0]   shifted_len;
    logic [LEN_BITS-1:0]   period_len;
    logic [LEN_BITS-1:0]   tone_dec;
    logic [LEN_BITS-1:0]   gap_dec;
    logic signed [OUT_BITS-1:0] lut_sample;

    nstg_sine_lut u_lut (
        .phase  (phase_acc_reg),
        .sample (lut_sample)
    );

    // Item moves on when the result register is free or drains this cycle
    assign item_take = item_valid && (!out_valid_reg || out_ready);

    // Period length, never below one tick
    assign shifted_len = whole_len >> item.value_code;
    assign period_len  = (shifted_len == '0) ? LEN_BITS'(1) : shifted_len;

    assign tone_dec = (tone_left_reg != '0) ? tone_left_reg - LEN_BITS'(1) : '0;
    assign gap_dec  = (gap_left_reg != '0) ? gap_left_reg - LEN_BITS'(1) : '0;

    // Command decode and tick sequencing
    always_comb begin
        phase_acc_next  = phase_acc_reg;
        phase_step_next = phase_step_reg;
        tone_left_next  = tone_left_reg;
        gap_left_next   = gap_left_reg;
        mode_next       = mode_reg;
        sample_next     = '0;
        kind_next       = MODE_IDLE;
        last_next       = 1'b0;
        emit            = 1'b0;
        unique case (item.cmd)
            CMD_NOTE: begin
                phase_acc_next  = '0;
                phase_step_next = BASE_STEP_ROM[item.note_index] << item.octave;
                tone_left_next  = period_len;
                gap_left_next   = period_len;
                mode_next       = MODE_TONE;
            end
            CMD_REST: begin
                tone_left_next = '0;
                gap_left_next  = period_len;
                mode_next      = MODE_GAP;
            end
            CMD_TICK: begin
                emit = 1'b1;
                unique case (mode_reg)
                    MODE_TONE: begin
                        kind_next      = MODE_TONE;
                        sample_next    = lut_sample;
                        phase_acc_next = phase_acc_reg + phase_step_reg;
                        tone_left_next = tone_dec;
                        if (tone_dec == '0) begin
                            mode_next = MODE_GAP;
                        end
                    end
                    MODE_GAP: begin
                        kind_next     = MODE_GAP;
                        gap_left_next = gap_dec;
                        if (gap_dec == '0) begin
                            last_next = 1'b1;
                            mode_next = MODE_IDLE;
                        end
                    end
                    default: begin
                        kind_next = MODE_IDLE;
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // Sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_acc_reg  <= '0;
            phase_step_reg <= '0;
            tone_left_reg  <= '0;
            gap_left_reg   <= '0;
            mode_reg       <= MODE_IDLE;
        end else if (item_take) begin
            phase_acc_reg  <= phase_acc_next;
            phase_step_reg <= phase_step_next;
            tone_left_reg  <= tone_left_next;
            gap_left_reg   <= gap_left_next;
            mode_reg       <= mode_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (item_take && emit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_take && emit) begin
            sample_reg <= sample_next;
            kind_reg   <= kind_next;
            last_reg   <= last_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = sample_reg;
    assign out_kind   = kind_reg;
    assign out_last   = last_reg;

endmodule

`default_nettype wire
